// ----- design/segmented_memory_load_store_top_defines.svh -----
// Assertion macros for the design file that carries assertions.
`ifndef SEGMENTED_MEMORY_LOAD_STORE_TOP_DEFINES_SVH
`define SEGMENTED_MEMORY_LOAD_STORE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SMLS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold once the delay given by dly has passed after the antecedent.
`define SMLS_ASSERT_LATER(label, clk, rst, ante, dly, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

// ----- design/smls_pkg.sv -----
package smls_pkg;

  localparam int BYTE_W = 8;
  localparam int LANES  = 4;

  localparam int          MEM_BYTES_DEF      = 65536;
  localparam int          DATA_OFFSET_DEF    = 16384;
  localparam int          STACK_OFFSET_DEF   = 32768;
  localparam logic [31:0] DATA_BASE_ADDR_DEF = 32'h1000_0000;
  localparam logic [31:0] STACK_TOP_ADDR_DEF = 32'h8000_0000;

  localparam logic KIND_STORE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SEGV  = 2'd1,
    ST_ALIGN = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    SIZE_BYTE = 2'd0,
    SIZE_HALF = 2'd1,
    SIZE_WORD = 2'd2
  } size_t;

endpackage

// ----- design/smls_bank.sv -----
module smls_bank #(
  parameter int ROWS = 16384,
  parameter int RW   = 14
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [RW-1:0]               row,
  input  logic [smls_pkg::BYTE_W-1:0] wdata,
  output logic [smls_pkg::BYTE_W-1:0] rdata
);

  logic [smls_pkg::BYTE_W-1:0] mem [ROWS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[row] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[row];
  end

endmodule

// ----- design/segmented_memory_load_store_top.sv -----
// Segmented data memory with one load or store access per item.
// An item is taken at a rising edge where start is high and busy is low; the
// inputs are kind, address, size_code, store_data and align_en.
// Every item gives exactly one result: read_data, status and fault_address
// are valid for the single cycle in which done is high. Results leave in
// the order the items came in.
// A new item may be taken in every cycle. The first stage maps the virtual
// address to a physical offset, the second checks region bounds and
// alignment and drives the four byte banks, the third assembles the load
// data from the registered bank outputs. A store in one cycle is visible to
// a load issued in the next, since both act in the same stage.
// Memory is four byte-wide banks, one per byte lane, so any size at any
// byte offset costs a single access to each bank.
// The receiver cannot hold results off; done is never held.
// While rst is high busy is high and no item is taken; reset clears the
// pipeline valid flags. Memory contents are not cleared and hold nothing
// meaningful until written.
`include "segmented_memory_load_store_top_defines.svh"

module segmented_memory_load_store_top #(
  parameter int          MEM_BYTES      = smls_pkg::MEM_BYTES_DEF,
  parameter int          DATA_OFFSET    = smls_pkg::DATA_OFFSET_DEF,
  parameter int          STACK_OFFSET   = smls_pkg::STACK_OFFSET_DEF,
  parameter logic [31:0] DATA_BASE_ADDR = smls_pkg::DATA_BASE_ADDR_DEF,
  parameter logic [31:0] STACK_TOP_ADDR = smls_pkg::STACK_TOP_ADDR_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        kind,
  input  logic [31:0] address,
  input  logic [1:0]  size_code,
  input  logic [31:0] store_data,
  input  logic        align_en,
  output logic        done,
  output logic [31:0] read_data,
  output logic [1:0]  status,
  output logic [31:0] fault_address
);

  localparam int LANES      = smls_pkg::LANES;
  localparam int BW         = smls_pkg::BYTE_W;
  localparam int STACK_SIZE = (MEM_BYTES > STACK_OFFSET) ? MEM_BYTES - STACK_OFFSET : 0;
  localparam int DATA_SIZE  = (STACK_OFFSET > DATA_OFFSET) ? STACK_OFFSET - DATA_OFFSET : 0;
  localparam int TOP_MD     = (MEM_BYTES > DATA_OFFSET) ? MEM_BYTES : DATA_OFFSET;
  localparam int TOP_OFF    = (TOP_MD > STACK_OFFSET) ? TOP_MD : STACK_OFFSET;
  // Offsets plus an access length must fit without wrapping.
  localparam int OW         = $clog2(TOP_OFF + 5);
  localparam int ROWS       = (MEM_BYTES + LANES - 1) / LANES;
  localparam int RW         = $clog2(ROWS);

  // Mapping stage registers.
  logic        a_valid;
  logic        a_kind;
  logic [31:0] a_addr;
  logic [1:0]  a_size;
  logic [31:0] a_wdata;
  logic        a_chk;

  // Check and access stage registers.
  logic          b_valid;
  logic          b_kind;
  logic [31:0]   b_addr;
  logic [1:0]    b_size;
  logic [31:0]   b_wdata;
  logic          b_chk;
  logic          b_mapped;
  logic [OW-1:0] b_off;

  // Result stage registers.
  logic              c_valid;
  smls_pkg::status_t c_status;
  logic [31:0]       c_faddr;
  logic              c_load_ok;
  logic [1:0]        c_lane;
  logic [2:0]        c_nbytes;

  logic          accept;
  logic [31:0]   top_diff;
  logic [31:0]   data_diff;
  logic          stack_hit;
  logic          data_hit;
  logic          text_hit;
  logic          mapped_next;
  logic [OW-1:0] off_next;

  logic              size_ok;
  logic [2:0]        nbytes;
  logic [1:0]        align_mask;
  logic [OW-1:0]     off_end;
  logic              segv;
  logic              misalign;
  smls_pkg::status_t status_next;
  logic [31:0]       faddr_next;
  logic              access_ok;

  logic          bank_we    [LANES];
  logic [RW-1:0] bank_row   [LANES];
  logic [BW-1:0] bank_wdata [LANES];
  logic [BW-1:0] bank_rdata [LANES];

  logic res_fault;
  logic res_align;

  assign busy   = rst;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      a_valid <= accept;
      b_valid <= a_valid;
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_kind  <= kind;
      a_addr  <= address;
      a_size  <= size_code;
      a_wdata <= store_data;
      a_chk   <= align_en;
    end
  end

  // Address mapping: stack first, then data, then text.
  always_comb begin
    top_diff  = STACK_TOP_ADDR - a_addr;
    data_diff = a_addr - DATA_BASE_ADDR;
    stack_hit = (a_addr < STACK_TOP_ADDR) && (top_diff <= 32'(STACK_SIZE));
    data_hit  = (a_addr >= DATA_BASE_ADDR) && (data_diff < 32'(DATA_SIZE));
    text_hit  = a_addr < 32'(DATA_OFFSET);
    mapped_next = stack_hit || data_hit || text_hit;
    if (stack_hit) begin
      off_next = OW'(MEM_BYTES) - top_diff[OW-1:0];
    end else if (data_hit) begin
      off_next = data_diff[OW-1:0] + OW'(DATA_OFFSET);
    end else begin
      off_next = a_addr[OW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    b_kind   <= a_kind;
    b_addr   <= a_addr;
    b_size   <= a_size;
    b_wdata  <= a_wdata;
    b_chk    <= a_chk;
    b_mapped <= mapped_next;
    b_off    <= off_next;
  end

  always_comb begin
    size_ok    = 1'b1;
    nbytes     = 3'd1;
    align_mask = 2'b00;
    case (b_size)
      smls_pkg::SIZE_BYTE: begin
        nbytes     = 3'd1;
        align_mask = 2'b00;
      end
      smls_pkg::SIZE_HALF: begin
        nbytes     = 3'd2;
        align_mask = 2'b01;
      end
      smls_pkg::SIZE_WORD: begin
        nbytes     = 3'd4;
        align_mask = 2'b11;
      end
      default: begin
        size_ok = 1'b0;
      end
    endcase
  end

  // Region bounds: stores stay inside data and stack and may not run from
  // data into stack; loads may not cross the end of any region.
  always_comb begin
    off_end = b_off + OW'(nbytes);
    if (!size_ok || !b_mapped) begin
      segv = 1'b1;
    end else if (b_kind == smls_pkg::KIND_STORE) begin
      segv = (b_off < OW'(DATA_OFFSET)) || (off_end > OW'(MEM_BYTES)) ||
             ((b_off < OW'(STACK_OFFSET)) && (off_end > OW'(STACK_OFFSET)));
    end else begin
      segv = ((b_off < OW'(DATA_OFFSET)) && (off_end > OW'(DATA_OFFSET))) ||
             ((b_off >= OW'(DATA_OFFSET)) && (b_off < OW'(STACK_OFFSET)) &&
              (off_end > OW'(STACK_OFFSET))) ||
             (off_end > OW'(MEM_BYTES));
    end
    misalign = b_chk && ((b_off[1:0] & align_mask) != 2'b00);
    if (segv) begin
      status_next = smls_pkg::ST_SEGV;
      faddr_next  = b_addr;
    end else if (misalign) begin
      status_next = smls_pkg::ST_ALIGN;
      faddr_next  = 32'(b_off);
    end else begin
      status_next = smls_pkg::ST_OK;
      faddr_next  = '0;
    end
    access_ok = b_valid && !segv && !misalign;
  end

  // Byte i of the access lands in bank (offset + i) mod 4; banks below the
  // starting lane take the next row.
  always_comb begin
    logic [1:0]  idx;
    logic [OW-2:0] row_full;
    for (int b = 0; b < LANES; b++) begin
      idx      = 2'(b) - b_off[1:0];
      row_full = {1'b0, b_off[OW-1:2]} + (OW-1)'(2'(b) < b_off[1:0]);
      bank_row[b]   = row_full[RW-1:0];
      bank_wdata[b] = BW'(b_wdata >> {idx, 3'b000});
      bank_we[b]    = access_ok && (b_kind == smls_pkg::KIND_STORE) &&
                      ({1'b0, idx} < nbytes);
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_bank
    smls_bank #(
      .ROWS (ROWS),
      .RW   (RW)
    ) u_bank (
      .clk   (clk),
      .we    (bank_we[g]),
      .row   (bank_row[g]),
      .wdata (bank_wdata[g]),
      .rdata (bank_rdata[g])
    );
  end

  always_ff @(posedge clk) begin
    c_status  <= status_next;
    c_faddr   <= faddr_next;
    c_load_ok <= access_ok && (b_kind != smls_pkg::KIND_STORE);
    c_lane    <= b_off[1:0];
    c_nbytes  <= nbytes;
  end

  always_comb begin
    read_data = '0;
    for (int i = 0; i < LANES; i++) begin
      if (c_load_ok && (3'(i) < c_nbytes)) begin
        read_data[BW*i +: BW] = bank_rdata[2'(c_lane + 2'(i))];
      end
    end
  end

  assign done          = c_valid;
  assign status        = c_status;
  assign fault_address = c_faddr;

  assign res_fault = done && (status != smls_pkg::ST_OK);
  assign res_align = done && (status == smls_pkg::ST_ALIGN);

  `SMLS_ASSERT_LATER(a_result_latency, clk, rst, accept, 3, done, "item gave no result")
  `SMLS_ASSERT_NOW(a_fault_zero_data, clk, rst, res_fault, read_data == 32'd0, "fault gave data")
  `SMLS_ASSERT_NOW(a_align_offset, clk, rst, res_align, fault_address[1:0] != 2'b00, "bad align")

endmodule
